// ===== rtl/fir_lowpass_25tap_top_assert.svh =====
// Assertion macros shared by the filter RTL.
`ifndef FIR_LOWPASS_25TAP_TOP_ASSERT_SVH
`define FIR_LOWPASS_25TAP_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define FLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define FLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/flp25_pkg.sv =====
// Package for the 25-tap low-pass filter: defaults, coefficient ROM and sequencer states.
package flp25_pkg;

  localparam int TAP_COUNT_DEF   = 25;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 16;
  localparam int ROM_TAPS        = 25;

  // Q1.15 taps, symmetric about the centre tap
  localparam logic signed [15:0] COEF_Q15 [ROM_TAPS] = '{
    -16'sd66, 16'sd53, 16'sd0, -16'sd147, 16'sd385, -16'sd598, 16'sd553, 16'sd0,
    -16'sd1183, 16'sd2867, -16'sd4664, 16'sd6048, 16'sd26270,
    16'sd6048, -16'sd4664, 16'sd2867, -16'sd1183, 16'sd0, 16'sd553, -16'sd598,
    16'sd385, -16'sd147, 16'sd0, 16'sd53, -16'sd66
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_ROUND,
    ST_SAT
  } state_t;

  // Tap k rescaled to Q1.(coef_bits-1); taps past the stored set are zero.
  // Narrower formats round half up.
  function automatic int coef_at(logic [5:0] k, int coef_bits);
    int c;
    c = 0;
    if (k < 6'(ROM_TAPS)) begin
      c = int'(COEF_Q15[k[4:0]]);
    end
    if (coef_bits >= 16) begin
      return c <<< (coef_bits - 16);
    end
    return (c + (1 <<< (15 - coef_bits))) >>> (16 - coef_bits);
  endfunction

endpackage

// ===== rtl/fir_lowpass_25tap_top.sv =====
// Direct-form FIR low-pass filter with one shared multiply-accumulate unit.
//
//  Channel | Ports                                 | Direction | Beat
//  --------+---------------------------------------+-----------+-----------------------------
//  in      | in_valid, in_ready, in_sample         | input     | one signed sample
//  out     | out_valid, out_ready, out_filtered,   | output    | one filtered sample + clip
//          | out_saturated                         |           | flag
//
//  A sample passes through these steps from accept to result: the accept
//  cycle, one multiply per tap through the single multiplier, a flush step to
//  add the last product, a round step and a saturate step.
//  in_ready is high only while the sequencer is idle; a finished result waits in
//  the output register, and the next sample may be taken meanwhile.
//  The saturate step holds while an earlier result is still unclaimed.
//  Synchronous active-low reset clears the delay line, sequencer and out_valid.
module fir_lowpass_25tap_top #(
  parameter int TAP_COUNT   = flp25_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_BITS = flp25_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = flp25_pkg::COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_filtered,
  output logic                          out_saturated
);

  `include "fir_lowpass_25tap_top_assert.svh"

  localparam int CNT_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + CNT_W + 1;
  localparam int FRAC   = COEF_BITS - 1;

  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (FRAC - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -(ACC_W'(1) <<< (SAMPLE_BITS - 1));

  flp25_pkg::state_t state_r, state_nxt;

  // Window of the newest TAP_COUNT samples, entry 0 newest. During the MAC
  // pass it rotates once per tap so the multiplier always reads the last entry.
  logic signed [SAMPLE_BITS-1:0] line_r [TAP_COUNT];

  logic [CNT_W-1:0]         cnt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pvld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic signed [SAMPLE_BITS-1:0] filt_r;
  logic                     sat_r;

  logic                      accept;
  logic                      mac_en;
  logic                      rnd_en;
  logic                      sat_en;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic                      y_hi;
  logic                      y_lo;

  assign accept = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      flp25_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = flp25_pkg::ST_MAC;
      end
      flp25_pkg::ST_MAC: begin
        if (cnt_r == '0) state_nxt = flp25_pkg::ST_FLUSH;
      end
      flp25_pkg::ST_FLUSH: state_nxt = flp25_pkg::ST_ROUND;
      flp25_pkg::ST_ROUND: state_nxt = flp25_pkg::ST_SAT;
      flp25_pkg::ST_SAT: begin
        if (!out_valid_r || out_ready) state_nxt = flp25_pkg::ST_IDLE;
      end
      default: state_nxt = flp25_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    mac_en   = 1'b0;
    rnd_en   = 1'b0;
    sat_en   = 1'b0;
    unique case (state_r)
      flp25_pkg::ST_IDLE:  in_ready = 1'b1;
      flp25_pkg::ST_MAC:   mac_en   = 1'b1;
      flp25_pkg::ST_FLUSH: ;
      flp25_pkg::ST_ROUND: rnd_en   = 1'b1;
      flp25_pkg::ST_SAT:   sat_en   = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Shared multiplier: current tap coefficient times the last window entry.
  assign coef     = COEF_BITS'(flp25_pkg::coef_at(6'(cnt_r), COEF_BITS));
  assign prod_nxt = PROD_W'(line_r[TAP_COUNT-1]) * PROD_W'(coef);

  // Clip detection on the rounded sum held in acc_r.
  assign y_hi = acc_r > Y_MAX;
  assign y_lo = acc_r < Y_MIN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flp25_pkg::ST_IDLE;
      pvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < TAP_COUNT; i++) begin
        line_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pvld_r  <= mac_en;

      // Shift the new sample in, or rotate the window one tap per MAC cycle.
      if (accept) begin
        line_r[0] <= in_sample;
        for (int i = 1; i < TAP_COUNT; i++) begin
          line_r[i] <= line_r[i-1];
        end
        cnt_r <= CNT_W'(TAP_COUNT - 1);
      end else if (mac_en) begin
        line_r[0] <= line_r[TAP_COUNT-1];
        for (int i = 1; i < TAP_COUNT; i++) begin
          line_r[i] <= line_r[i-1];
        end
        cnt_r <= cnt_r - CNT_W'(1);
      end

      // Load a fresh result, or drop the held one once it is taken.
      if (sat_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    priority if (accept) begin
      acc_r <= '0;
    end else if (pvld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end else if (rnd_en) begin
      acc_r <= (acc_r + HALF) >>> FRAC;
    end else begin
      acc_r <= acc_r;
    end
    if (sat_en) begin
      priority if (y_hi) begin
        filt_r <= Y_MAX[SAMPLE_BITS-1:0];
      end else if (y_lo) begin
        filt_r <= Y_MIN[SAMPLE_BITS-1:0];
      end else begin
        filt_r <= acc_r[SAMPLE_BITS-1:0];
      end
      sat_r <= y_hi || y_lo;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = filt_r;
  assign out_saturated = sat_r;

  `FLP_ASSERT_NXT(a_accept_starts_mac, accept,
    (state_r == flp25_pkg::ST_MAC) && (cnt_r == CNT_W'(TAP_COUNT - 1)),
    "accepted sample did not start a full MAC pass")
  `FLP_ASSERT_NXT(a_mac_ends, (state_r == flp25_pkg::ST_MAC) && (cnt_r == '0),
    (state_r == flp25_pkg::ST_FLUSH) && pvld_r,
    "MAC pass did not end in the flush step")
  `FLP_ASSERT_NXT(a_sat_loads, sat_en,
    out_valid_r && (state_r == flp25_pkg::ST_IDLE),
    "saturate step did not present a result")
  `FLP_ASSERT_IMP(a_clip_value, out_valid_r && sat_r,
    (filt_r == Y_MAX[SAMPLE_BITS-1:0]) || (filt_r == Y_MIN[SAMPLE_BITS-1:0]),
    "clip flag set on an unclipped value")

endmodule
